// ===== sv/ktsi_pkg.sv =====
// knot table spline interpolator: shared types, codes and helpers
// no dependencies; used by ktsi_mul, ktsi_div and the top level
`default_nettype none

package ktsi_pkg;

    // magnitude limit of one fixed-point product, 2^56 - 1
    localparam logic [63:0] K_LIM = 64'h00FF_FFFF_FFFF_FFFF;

    // operation codes
    localparam logic [1:0] OP_WRITE      = 2'd0;
    localparam logic [1:0] OP_UNIFORM    = 2'd1;
    localparam logic [1:0] OP_NONUNIFORM = 2'd2;
    localparam logic [1:0] OP_BEZIER     = 2'd3;

    // configuration register indexes
    localparam logic CFG_KNOT_COUNT = 1'b0;
    localparam logic CFG_FLAT_TOL   = 1'b1;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] q;
        logic [63:0]        lo;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ktsi_req_if.sv =====
// request channel of the knot table spline interpolator
// valid/ready handshake with the input fields as payload; no dependencies
`default_nettype none

interface ktsi_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [5:0]         first_index;
    logic [5:0]         second_index;
    logic [5:0]         third_index;
    logic signed [31:0] position;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;

    modport source (
        output valid, operation, first_index, second_index, third_index,
               position, knot_x, knot_y,
        input  ready
    );
    modport sink (
        input  valid, operation, first_index, second_index, third_index,
               position, knot_x, knot_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/ktsi_rsp_if.sv =====
// result channel of the knot table spline interpolator
// valid/ready handshake with the result fields as payload; no dependencies
`default_nettype none

interface ktsi_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic               status;

    modport source (output valid, value_x, value_y, status, input ready);
    modport sink (input valid, value_x, value_y, status, output ready);
endinterface

`default_nettype wire

// ===== sv/knot_table_spline_interpolator_unit.sv =====
// knot table spline interpolator, top level: knot memory, sequencer, result register
// products are computed in ktsi_mul, divisions and the modulo in ktsi_div
// throughput: one transaction in flight; the next one is taken once the sequencer is idle
// reset: synchronous active low, clears control and config; knot memory is not cleared
// depends on ktsi_pkg, ktsi_req_if, ktsi_rsp_if, ktsi_mul, ktsi_div
`default_nettype none

module knot_table_spline_interpolator_unit
    import ktsi_pkg::*;
#(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data,
    ktsi_req_if.sink    i_req,
    ktsi_rsp_if.source  o_rsp
);

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int NW = ($clog2(MAX_KNOTS + 1) > 7) ? $clog2(MAX_KNOTS + 1) : 7;
    localparam logic [32:0] HALF = 33'd1 << (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;   // wait for round(position) mod count
    localparam logic [2:0] S_RD   = 3'd2;   // stream knots out of memory
    localparam logic [2:0] S_CHK  = 3'd3;   // flat segment check
    localparam logic [2:0] S_EXEC = 3'd4;   // launch arithmetic step
    localparam logic [2:0] S_WAIT = 3'd5;   // wait and fold result in
    localparam logic [2:0] S_DONE = 3'd6;   // hand result to output register

    // config
    logic [6:0]  r_knot_count;
    logic [30:0] r_flat_tol;

    // knot memory: {x, y} per entry, one write port, one registered read port
    logic [63:0] r_mem [MAX_KNOTS];
    logic [63:0] r_mem_q;
    logic        w_mem_we;
    logic [AW-1:0] w_mem_wa;
    logic [AW-1:0] w_mem_ra;

    // sequencer
    logic [2:0]         r_state;
    logic [1:0]         r_op;
    logic signed [31:0] r_pos;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_idx [4];
    logic [2:0]         r_rd_cnt;
    logic [2:0]         r_rd_num;
    logic signed [31:0] r_x [4];
    logic signed [31:0] r_y [4];
    logic [3:0]         r_step;
    logic               r_rneg;
    logic signed [FRAC_BITS:0] r_f;

    // working values
    logic signed [63:0] r_acc;
    logic [63:0]        r_lo;
    logic signed [63:0] r_m0;
    logic signed [63:0] r_ca;
    logic signed [63:0] r_cb;
    logic signed [63:0] r_t;
    logic signed [63:0] r_w [3];
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic               r_st;

    // output register
    logic               r_o_valid;
    logic signed [31:0] r_o_vx;
    logic signed [31:0] r_o_vy;
    logic               r_o_st;

    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic               w_acc_in;
    logic [NW-1:0]      w_n;
    logic [NW-1:0]      w_k0;
    logic [NW-1:0]      w_k1;
    logic [NW-1:0]      w_k2;
    logic [32:0]        w_v;
    logic signed [32:0] w_r;
    logic [32:0]        w_rmag;
    logic signed [FRAC_BITS:0] w_f;
    logic [NW:0]        w_p1;
    logic [NW:0]        w_p2;
    logic [NW:0]        w_last;
    logic [NW-1:0]      w_rem_n;
    logic [NW-1:0]      w_m;
    logic [NW:0]        w_s1;
    logic [NW:0]        w_s2;
    logic [NW:0]        w_s2b;
    logic [NW:0]        w_ne;
    logic signed [32:0] w_x21;
    logic               w_flat;
    logic signed [63:0] w_xe [4];
    logic signed [63:0] w_ye [4];
    logic signed [63:0] w_x21e;
    logic signed [63:0] w_c1;
    logic signed [63:0] w_c2;
    logic signed [63:0] w_c3;
    logic signed [63:0] w_dy0;
    logic signed [63:0] w_dx0;
    logic signed [63:0] w_dy1;
    logic signed [63:0] w_dx1;
    logic signed [63:0] w_pd;
    logic signed [63:0] w_bt;
    logic signed [63:0] w_bu;
    logic signed [63:0] w_s1new;
    logic signed [63:0] w_qt;
    logic signed [63:0] w_mq;
    logic               w_use_div;
    logic               w_unit_done;
    logic [3:0]         w_last_step;
    logic [1:0]         w_cap;

    // slope from the quotient |dy|*x21/|dx|: clamped, signed, zero on a zero gap
    function automatic logic signed [63:0] slope_fin(
        input logic [63:0]        quo,
        input logic signed [63:0] dy,
        input logic signed [63:0] dx
    );
        logic [63:0]        q;
        logic signed [63:0] r;
        q = (quo > K_LIM) ? K_LIM : quo;
        if (dx == 64'sd0) begin
            r = '0;
        end else if (dy[63] != dx[63]) begin
            r = -$signed(q);
        end else begin
            r = $signed(q);
        end
        return r;
    endfunction

    ktsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    ktsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign w_acc_in      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_o_valid;
    assign o_rsp.value_x = r_o_vx;
    assign o_rsp.value_y = r_o_vy;
    assign o_rsp.status  = r_o_st;

    // knots in use, a count above the table size acts as the table size
    always_comb begin
        w_n  = (NW'(r_knot_count) > NW'(MAX_KNOTS)) ? NW'(MAX_KNOTS) : NW'(r_knot_count);
        w_k0 = NW'(i_req.first_index);
        w_k1 = NW'(i_req.second_index);
        w_k2 = NW'(i_req.third_index);
    end

    // uniform query: r = floor((position + half) / one), frac around zero
    always_comb begin
        w_v    = {i_req.position[31], i_req.position} + HALF;
        w_r    = $signed(w_v) >>> FRAC_BITS;
        w_rmag = w_r[32] ? 33'(-w_r) : 33'(w_r);
        w_f    = $signed({1'b0, w_v[FRAC_BITS-1:0]}) - $signed(HALF[FRAC_BITS:0]);
    end

    // non-uniform neighbours, clamped to the table
    always_comb begin
        w_last = {1'b0, w_n} - (NW+1)'(1);
        w_p1   = {1'b0, w_k0} + (NW+1)'(1);
        w_p2   = {1'b0, w_k0} + (NW+1)'(2);
    end

    // uniform neighbours, wrapped around the table
    always_comb begin
        w_ne    = {1'b0, r_n};
        w_rem_n = w_div_rsp.rem[NW-1:0];
        w_m     = (r_rneg && w_rem_n != '0) ? r_n - w_rem_n : w_rem_n;
        w_s1    = {1'b0, w_m} + (NW+1)'(1);
        w_s2    = {1'b0, w_m} + (NW+1)'(2);
        w_s2b   = (w_s2 >= w_ne) ? w_s2 - w_ne : w_s2;
    end

    // datapath operands
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_xe[i] = 64'(r_x[i]);
            w_ye[i] = 64'(r_y[i]);
        end
        w_x21  = $signed({r_x[2][31], r_x[2]}) - $signed({r_x[1][31], r_x[1]});
        w_flat = (w_x21 < $signed({2'b00, r_flat_tol})) || (w_x21 <= 33'sd0);
        w_x21e = 64'(w_x21);
        w_c1   = w_ye[2] - w_ye[0];
        w_c2   = 64'sd2 * w_ye[0] - 64'sd5 * w_ye[1] + 64'sd4 * w_ye[2] - w_ye[3];
        w_c3   = 64'sd3 * (w_ye[1] - w_ye[2]) + (w_ye[3] - w_ye[0]);
        w_dy0  = w_ye[2] - w_ye[0];
        w_dx0  = w_xe[2] - w_xe[0];
        w_dy1  = w_ye[3] - w_ye[1];
        w_dx1  = w_xe[3] - w_xe[1];
        w_pd   = 64'(r_pos) - w_xe[1];
        w_bt   = 64'(r_pos);
        w_bu   = ONE - w_bt;
        w_s1new = slope_fin(w_div_rsp.quo, w_dy1, w_dx1);
        w_qt   = $signed(w_div_rsp.quo);
        w_mq   = w_mul_rsp.q;
    end

    // which unit each step uses, and the final step of each operation
    always_comb begin
        w_use_div = (r_op == OP_NONUNIFORM) &&
                    (r_step == 4'd1 || r_step == 4'd3 || r_step == 4'd4);
        w_unit_done = w_use_div ? w_div_rsp.done : w_mul_rsp.done;
        case (r_op)
            OP_UNIFORM:    w_last_step = 4'd2;
            OP_NONUNIFORM: w_last_step = 4'd7;
            default:       w_last_step = 4'd8;
        endcase
    end

    // unit requests
    always_comb begin
        w_mul_req = '0;
        w_div_req = '0;
        if (r_state == S_IDLE) begin
            // r mod count starts as the query is taken
            w_div_req.start = w_acc_in && (i_req.operation == OP_UNIFORM) && (w_n != '0);
            w_div_req.num   = 64'(w_rmag);
            w_div_req.den   = 64'(w_n);
        end else if (r_state == S_EXEC) begin
            w_mul_req.start = !w_use_div;
            w_div_req.start = w_use_div;
            case (r_op)
                OP_UNIFORM: begin
                    w_mul_req.a = (r_step == 4'd0) ? w_c3 : r_acc;
                    w_mul_req.b = 64'(r_f);
                end
                OP_NONUNIFORM: begin
                    case (r_step)
                        4'd0: begin
                            w_mul_req.a = $signed(mag64(w_dy0));
                            w_mul_req.b = w_x21e;
                        end
                        4'd1: begin
                            w_div_req.num = r_lo;
                            w_div_req.den = mag64(w_dx0);
                        end
                        4'd2: begin
                            w_mul_req.a = $signed(mag64(w_dy1));
                            w_mul_req.b = w_x21e;
                        end
                        4'd3: begin
                            w_div_req.num = r_lo;
                            w_div_req.den = mag64(w_dx1);
                        end
                        4'd4: begin
                            w_div_req.num = mag64(w_pd) << FRAC_BITS;
                            w_div_req.den = 64'(w_x21e);
                        end
                        4'd5: begin
                            w_mul_req.a = r_t;
                            w_mul_req.b = r_ca;
                        end
                        default: begin
                            w_mul_req.a = r_t;
                            w_mul_req.b = r_acc;
                        end
                    endcase
                end
                default: begin
                    // bezier: weights u*u, u*t, t*t, then weighted x and y
                    case (r_step)
                        4'd0: begin
                            w_mul_req.a = w_bu;
                            w_mul_req.b = w_bu;
                        end
                        4'd1: begin
                            w_mul_req.a = w_bu;
                            w_mul_req.b = w_bt;
                        end
                        4'd2: begin
                            w_mul_req.a = w_bt;
                            w_mul_req.b = w_bt;
                        end
                        4'd3: begin
                            w_mul_req.a = r_w[0];
                            w_mul_req.b = w_xe[0];
                        end
                        4'd4: begin
                            w_mul_req.a = r_w[1];
                            w_mul_req.b = w_xe[1];
                        end
                        4'd5: begin
                            w_mul_req.a = r_w[2];
                            w_mul_req.b = w_xe[2];
                        end
                        4'd6: begin
                            w_mul_req.a = r_w[0];
                            w_mul_req.b = w_ye[0];
                        end
                        4'd7: begin
                            w_mul_req.a = r_w[1];
                            w_mul_req.b = w_ye[1];
                        end
                        default: begin
                            w_mul_req.a = r_w[2];
                            w_mul_req.b = w_ye[2];
                        end
                    endcase
                end
            endcase
        end
    end

    // memory ports: writes only from a taken write transaction, reads from the sequencer
    always_comb begin
        w_mem_we = w_acc_in && (i_req.operation == OP_WRITE) && (w_k0 < NW'(MAX_KNOTS));
        w_mem_wa = w_k0[AW-1:0];
        w_mem_ra = r_idx[r_rd_cnt[1:0]][AW-1:0];
        w_cap    = 2'(r_rd_cnt - 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= {i_req.knot_x, i_req.knot_y};
        end
        r_mem_q <= r_mem[w_mem_ra];
    end

    // config writes, taken at any time the port is enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= '0;
            r_flat_tol   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KNOT_COUNT: r_knot_count <= i_cfg_data[6:0];
                CFG_FLAT_TOL:   r_flat_tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer; one transaction at a time, so a write never overlaps a read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_step    <= '0;
            r_rd_cnt  <= '0;
        end else begin
            // drained result; the done state handles the register itself
            if (o_rsp.ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_op     <= i_req.operation;
                        r_pos    <= i_req.position;
                        r_n      <= w_n;
                        r_vx     <= '0;
                        r_vy     <= '0;
                        r_st     <= 1'b0;
                        r_step   <= '0;
                        r_rd_cnt <= '0;
                        r_rneg   <= w_r[32];
                        r_f      <= w_f;
                        case (i_req.operation)
                            OP_WRITE: begin
                                r_st    <= !(w_k0 < NW'(MAX_KNOTS));
                                r_state <= S_DONE;
                            end
                            OP_UNIFORM: begin
                                r_rd_num <= 3'd4;
                                if (w_n == '0) begin
                                    r_st    <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_MOD;
                                end
                            end
                            OP_NONUNIFORM: begin
                                r_rd_num <= 3'd4;
                                r_idx[0] <= (w_k0 == '0) ? '0 : w_k0 - NW'(1);
                                r_idx[1] <= w_k0;
                                r_idx[2] <= (w_p1 > w_last) ? w_last[NW-1:0] : w_p1[NW-1:0];
                                r_idx[3] <= (w_p2 > w_last) ? w_last[NW-1:0] : w_p2[NW-1:0];
                                if (w_k0 >= w_n) begin
                                    r_st    <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_rd_num <= 3'd3;
                                r_idx[0] <= w_k0;
                                r_idx[1] <= w_k1;
                                r_idx[2] <= w_k2;
                                if (w_k0 >= w_n || w_k1 >= w_n || w_k2 >= w_n) begin
                                    r_st    <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (w_div_rsp.done) begin
                        r_idx[0] <= (w_m == '0) ? r_n - NW'(1) : w_m - NW'(1);
                        r_idx[1] <= w_m;
                        r_idx[2] <= (w_s1 >= w_ne) ? NW'(w_s1 - w_ne) : NW'(w_s1);
                        r_idx[3] <= (w_s2b >= w_ne) ? NW'(w_s2b - w_ne) : NW'(w_s2b);
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    // data of the address issued last cycle arrives now
                    if (r_rd_cnt != 3'd0) begin
                        r_x[w_cap] <= r_mem_q[63:32];
                        r_y[w_cap] <= r_mem_q[31:0];
                    end
                    if (r_rd_cnt == r_rd_num) begin
                        r_state <= S_CHK;
                    end else begin
                        r_rd_cnt <= r_rd_cnt + 3'd1;
                    end
                end
                S_CHK: begin
                    if (r_op == OP_NONUNIFORM && w_flat) begin
                        r_vy    <= r_y[2];
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_unit_done) begin
                        case (r_op)
                            OP_UNIFORM: begin
                                case (r_step)
                                    4'd0:    r_acc <= w_mq + w_c2;
                                    4'd1:    r_acc <= w_mq + w_c1;
                                    default: r_vy  <= sat32(w_ye[1] +
                                        ($signed(w_mq + {63'd0, w_mq[63]}) >>> 1));
                                endcase
                            end
                            OP_NONUNIFORM: begin
                                case (r_step)
                                    4'd0: r_lo <= w_mul_rsp.lo;
                                    4'd1: r_m0 <= slope_fin(w_div_rsp.quo, w_dy0, w_dx0);
                                    4'd2: r_lo <= w_mul_rsp.lo;
                                    4'd3: begin
                                        r_ca <= 64'sd2 * (w_ye[1] - w_ye[2]) + r_m0 + w_s1new;
                                        r_cb <= 64'sd3 * (w_ye[2] - w_ye[1]) - 64'sd2 * r_m0
                                                - w_s1new;
                                    end
                                    4'd4: r_t   <= w_pd[63] ? -w_qt : w_qt;
                                    4'd5: r_acc <= w_mq + r_cb;
                                    4'd6: r_acc <= w_mq + r_m0;
                                    default: r_vy <= sat32(w_ye[1] + w_mq);
                                endcase
                            end
                            default: begin
                                case (r_step)
                                    4'd0: r_w[0] <= w_mq;
                                    4'd1: r_w[1] <= w_mq;
                                    4'd2: r_w[2] <= w_mq;
                                    4'd3: r_acc  <= w_mq;
                                    4'd4: r_acc  <= r_acc + (w_mq <<< 1);
                                    4'd5: r_vx   <= sat32(r_acc + w_mq);
                                    4'd6: r_acc  <= w_mq;
                                    4'd7: r_acc  <= r_acc + (w_mq <<< 1);
                                    default: r_vy <= sat32(r_acc + w_mq);
                                endcase
                            end
                        endcase
                        if (r_step == w_last_step) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_DONE: begin
                    // output register free or being drained this cycle
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_vx    <= r_vx;
                        r_o_vy    <= r_vy;
                        r_o_st    <= r_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a taken transaction always leaves idle on the next edge
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_in |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after taking a transaction");

    // multiplier completions only arrive while the sequencer waits for them
    a_unit_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_WAIT))
        else $error("multiplier result arrived outside the wait state");

    // the read counter never runs past the number of knots to fetch
    a_read_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_rd_cnt <= r_rd_num))
        else $error("knot read counter overran");

    // a bad-index result carries zero values
    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_st) |-> (r_o_vx == 32'sd0 && r_o_vy == 32'sd0))
        else $error("bad-index result with nonzero value");

endmodule

`default_nettype wire

// ===== sv/ktsi_mul.sv =====
// sequential fixed-point multiplier: four 32x32 partial products, then
// shift by FRAC_BITS with saturation; depends on ktsi_pkg
`default_nettype none

module ktsi_mul
    import ktsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [63:0]        r_am;
    logic [63:0]        r_bm;
    logic               r_neg;
    logic [2:0]         r_cnt;
    logic               r_busy;
    logic [127:0]       r_acc;
    logic               r_done;
    logic signed [63:0] r_q;
    logic [63:0]        r_lo;

    logic [31:0]        w_ah;
    logic [31:0]        w_bh;
    logic [63:0]        w_pp;
    logic [127:0]       w_sh;
    logic               w_sat;
    logic [55:0]        w_mag;
    logic signed [63:0] w_qm;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_ah = r_am[31:0];
                w_bh = r_bm[31:0];
            end
            2'd1: begin
                w_ah = r_am[31:0];
                w_bh = r_bm[63:32];
            end
            2'd2: begin
                w_ah = r_am[63:32];
                w_bh = r_bm[31:0];
            end
            default: begin
                w_ah = r_am[63:32];
                w_bh = r_bm[63:32];
            end
        endcase
        w_pp = 64'(w_ah) * 64'(w_bh);
        case (r_cnt[1:0])
            2'd0:    w_sh = {64'd0, w_pp};
            2'd1:    w_sh = {32'd0, w_pp, 32'd0};
            2'd2:    w_sh = {32'd0, w_pp, 32'd0};
            default: w_sh = {w_pp, 64'd0};
        endcase
        w_sat = |r_acc[127:56+FRAC_BITS];
        w_mag = w_sat ? K_LIM[55:0] : r_acc[55+FRAC_BITS:FRAC_BITS];
        w_qm  = $signed({8'd0, w_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_am   <= mag64(i_req.a);
                r_bm   <= mag64(i_req.b);
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? -w_qm : w_qm;
                    r_lo   <= r_acc[63:0];
                end else begin
                    r_acc <= r_acc + w_sh;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.lo   = r_lo;

endmodule

`default_nettype wire

// ===== sv/ktsi_div.sv =====
// unsigned 64 by 64 bit restoring divider, one quotient bit per cycle
// depends on ktsi_pkg
`default_nettype none

module ktsi_div
    import ktsi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] w_t;
    logic [64:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_t    = {r_r, r_q[63]};
        w_ge   = w_t >= {1'b0, r_d};
        w_diff = w_t - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.num;
                r_r    <= '0;
                r_d    <= i_req.den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= w_ge ? w_diff[63:0] : w_t[63:0];
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_r;

endmodule

`default_nettype wire
